// ===== src/gtg_pkg.sv =====
// Shared types and constants of the go-to-goal PI controller.
// No dependencies; compile first.
`timescale 1ns / 1ps
`default_nettype none
package gtg_pkg;

  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 21;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_LIN   = 3'd0,
    REG_MAX_ANG   = 3'd1,
    REG_GATE_EN   = 3'd2,
    REG_DIST_KP   = 3'd3,
    REG_DIST_KI   = 3'd4,
    REG_HEAD_KP   = 3'd5,
    REG_HEAD_KI   = 3'd6,
    REG_ARRIVAL_R = 3'd7
  } cfg_reg_t;

  // Angles: Q2.30 inside the CORDIC, Q16 outside.
  localparam logic signed [33:0] PI_Q30       = 34'sd3373259426;
  localparam logic signed [21:0] PI_Q16       = 22'sd205887;
  localparam logic signed [21:0] TWO_PI_Q16   = 22'sd411775;
  localparam logic signed [21:0] GATE_Q16     = 22'sd10294;
  localparam logic [29:0]        INV_GAIN_Q30 = 30'd652032874;
  localparam logic signed [49:0] INT_MAX48    = 50'sd140737488355327;
  localparam logic signed [49:0] INT_MIN48    = -50'sd140737488355328;

  // Rounded atan(2^-i) in Q2.30.
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:    r = 30'd843314857;
      5'd1:    r = 30'd497837830;
      5'd2:    r = 30'd263043837;
      5'd3:    r = 30'd133525159;
      5'd4:    r = 30'd67021687;
      5'd5:    r = 30'd33543516;
      5'd6:    r = 30'd16775851;
      5'd7:    r = 30'd8388437;
      5'd8:    r = 30'd4194283;
      5'd9:    r = 30'd2097149;
      5'd31:   r = 30'd0;
      default: r = 30'd1 << (5'd30 - i);
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/gtg_in_if.sv =====
// Input channel of the go-to-goal controller: pose, goal and elapsed time.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface gtg_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [18:0] heading;
  logic signed [31:0] goal_x;
  logic signed [31:0] goal_y;
  logic        [15:0] elapsed_time;

  modport source (output valid, pos_x, pos_y, heading, goal_x, goal_y, elapsed_time,
                  input ready);
  modport sink (input valid, pos_x, pos_y, heading, goal_x, goal_y, elapsed_time,
                output ready);
endinterface
`default_nettype wire

// ===== src/gtg_out_if.sv =====
// Output channel of the go-to-goal controller: speed commands and arrival flag.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface gtg_out_if;
  logic               valid;
  logic               ready;
  logic        [20:0] linear_speed;
  logic signed [19:0] angular_speed;
  logic               arrived;

  modport source (output valid, linear_speed, angular_speed, arrived, input ready);
  modport sink (input valid, linear_speed, angular_speed, arrived, output ready);
endinterface
`default_nettype wire

// ===== src/go_to_goal_pi_controller_top.sv =====
// Go-to-goal PI controller: CORDIC vectoring, error shaping and two PI loops.
// Depends on gtg_pkg, gtg_in_if and gtg_out_if.
//
// Usage:
//  - in_ch carries one beat per control step: robot pose, goal point and
//    elapsed time. in_ch.ready is high only while the sequencer is idle.
//  - out_ch carries one beat per input beat: linear speed, angular speed and
//    the arrival flag, held in an output register until taken.
//  - cfg_we/cfg_index/cfg_data write the eight tuning registers; write them
//    only while no beat is in flight.
// Sequence: an accepted item runs the CORDIC loop (one rotation per cycle), then
//  the magnitude product, rounding, error shaping, the steps on the single shared
//  multiplier and the load into the output register. The next item is
//  accepted as soon as the sequencer is back in idle, so items are worked on
//  one at a time.
// Reset (rst, synchronous): clears both integrals, loads register defaults
//  and empties the output register.
// Stall: if out_ch is not taken, the finished result waits in the output
//  register; a following item may be accepted and worked on, and holds in its
//  final state until the output register frees.
`timescale 1ns / 1ps
`default_nettype none
module go_to_goal_pi_controller_top #(
  parameter int unsigned CORDIC_STEPS = 18
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  gtg_in_if.sink                                 in_ch,
  gtg_out_if.source                              out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [gtg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [gtg_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import gtg_pkg::*;

  localparam int unsigned IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [IW-1:0] LAST_ITER = IW'(CORDIC_STEPS - 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CORD  = 7'b0000010,
    S_MAG   = 7'b0000100,
    S_ROUND = 7'b0001000,
    S_ERR   = 7'b0010000,
    S_MUL   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;

  // Tuning registers
  logic [20:0] max_lin;
  logic [18:0] max_ang;
  logic        gate_en;
  logic [19:0] dist_kp, dist_ki, head_kp, head_ki, arrival_r;

  // Per-item working registers
  logic signed [35:0] x, y;
  logic signed [33:0] z;
  logic               vec_zero;
  logic [IW-1:0]      iter;
  logic signed [18:0] hd;
  logic [15:0]        dt;
  logic signed [33:0] dist_err;
  logic signed [19:0] bearing;
  logic signed [21:0] eyaw;
  logic               arr;
  logic [3:0]         step;
  logic signed [65:0] p;
  logic signed [54:0] lin, ang;

  // Persistent integrals
  logic signed [47:0] dint, hint;

  // Output register
  logic               ov;
  logic [20:0]        o_lin;
  logic signed [19:0] o_ang;
  logic               o_arr;
  logic               load_out;

  function automatic logic signed [47:0] sat48(input logic signed [47:0] acc,
                                               input logic signed [65:0] prod);
    logic signed [49:0] s;
    s = 50'(acc) + 50'(prod >>> 16);
    if (s > INT_MAX48) return 48'(INT_MAX48);
    if (s < INT_MIN48) return 48'(INT_MIN48);
    return 48'(s);
  endfunction

  // Accept, pre-rotation
  logic signed [32:0] dx, dy;
  assign dx = 33'(in_ch.goal_x) - 33'(in_ch.pos_x);
  assign dy = 33'(in_ch.goal_y) - 33'(in_ch.pos_y);

  logic in_acc;
  assign in_ch.ready = (state == S_IDLE);
  assign in_acc = in_ch.valid && in_ch.ready;

  // Load the output register once it is empty or being taken this cycle
  assign load_out = (state == S_OUT) && (!ov || out_ch.ready);

  // CORDIC rotation
  logic signed [35:0] xs, ys;
  logic signed [33:0] at;
  assign xs = x >>> iter;
  assign ys = y >>> iter;
  assign at = $signed({4'd0, atan_q30(5'(iter))});

  // Shared multiplier operands
  logic signed [35:0] mul_a;
  logic [29:0]        mul_b;
  always_comb begin
    mul_a = x;
    mul_b = INV_GAIN_Q30;
    if (state == S_MUL) begin
      case (step)
        4'd0: begin mul_a = 36'(dist_err); mul_b = 30'(dt); end
        4'd1: begin mul_a = 36'(eyaw); mul_b = 30'(dt); end
        4'd2: begin mul_a = 36'(dist_err); mul_b = 30'(dist_kp); end
        4'd3: begin mul_a = 36'($signed(dint[47:16])); mul_b = 30'(dist_ki); end
        4'd4: begin mul_a = $signed({20'd0, dint[15:0]}); mul_b = 30'(dist_ki); end
        4'd5: begin mul_a = 36'(eyaw); mul_b = 30'(head_kp); end
        4'd6: begin mul_a = 36'($signed(hint[47:16])); mul_b = 30'(head_ki); end
        4'd7: begin mul_a = $signed({20'd0, hint[15:0]}); mul_b = 30'(head_ki); end
        default: begin mul_a = 36'sd0; mul_b = 30'd0; end
      endcase
    end
  end

  // Error shaping, split from the rounding stage
  logic signed [34:0] mag_r;
  logic signed [34:0] ang_r;
  logic signed [21:0] e0, e1, e2;
  assign mag_r = 35'((p + 66'sd536870912) >>> 30);
  assign ang_r = (35'(z) + 35'sd8192) >>> 14;
  always_comb begin
    e0 = 22'(bearing) - 22'(hd);
    e1 = (e0 >= PI_Q16) ? e0 - TWO_PI_Q16 : e0;
    e2 = (e1 <= -PI_Q16) ? e1 + TWO_PI_Q16 : e1;
  end

  // Clamp
  logic signed [54:0] lin_c, ang_c, amax;
  assign amax = $signed({36'd0, max_ang});
  always_comb begin
    lin_c = lin;
    if (lin > $signed({34'd0, max_lin})) lin_c = $signed({34'd0, max_lin});
    if (lin < 55'sd0) lin_c = 55'sd0;
    ang_c = ang;
    if (ang > amax) ang_c = amax;
    if (ang < -amax) ang_c = -amax;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_lin   <= 21'd65536;
      max_ang   <= 19'd65536;
      gate_en   <= 1'b0;
      dist_kp   <= 20'd52429;
      dist_ki   <= 20'd13107;
      head_kp   <= 20'd65536;
      head_ki   <= 20'd0;
      arrival_r <= 20'd13107;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MAX_LIN:   max_lin   <= cfg_data;
        REG_MAX_ANG:   max_ang   <= cfg_data[18:0];
        REG_GATE_EN:   gate_en   <= cfg_data[0];
        REG_DIST_KP:   dist_kp   <= cfg_data[19:0];
        REG_DIST_KI:   dist_ki   <= cfg_data[19:0];
        REG_HEAD_KP:   head_kp   <= cfg_data[19:0];
        REG_HEAD_KI:   head_ki   <= cfg_data[19:0];
        REG_ARRIVAL_R: arrival_r <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  // Sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ov    <= 1'b0;
      dint  <= '0;
      hint  <= '0;
      iter  <= '0;
      step  <= '0;
    end else begin
      if (load_out) ov <= 1'b1;
      else if (out_ch.valid && out_ch.ready) ov <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            hd       <= in_ch.heading;
            dt       <= in_ch.elapsed_time;
            vec_zero <= (dx == 33'sd0) && (dy == 33'sd0);
            iter     <= '0;
            // fold the left half plane onto the right
            if (dx < 33'sd0) begin
              x <= -36'(dx);
              y <= -36'(dy);
              z <= (dy >= 33'sd0) ? PI_Q30 : -PI_Q30;
            end else begin
              x <= 36'(dx);
              y <= 36'(dy);
              z <= '0;
            end
            state <= S_CORD;
          end
        end
        S_CORD: begin
          if (y >= 36'sd0) begin
            x <= x + ys;
            y <= y - xs;
            z <= z + at;
          end else begin
            x <= x - ys;
            y <= y + xs;
            z <= z - at;
          end
          iter <= iter + 1'b1;
          if (iter == LAST_ITER) state <= S_MAG;
        end
        S_MAG: begin
          p     <= mul_a * $signed({1'b0, mul_b});
          state <= S_ROUND;
        end
        S_ROUND: begin
          dist_err <= vec_zero ? 34'sd0 : 34'(mag_r);
          bearing  <= vec_zero ? 20'sd0 : 20'(ang_r);
          state    <= S_ERR;
        end
        S_ERR: begin
          // inside the arrival radius drop both errors; the gate drops distance
          if (dist_err < $signed({14'd0, arrival_r})) begin
            arr      <= 1'b1;
            dist_err <= '0;
            eyaw     <= '0;
          end else begin
            arr  <= 1'b0;
            eyaw <= e2;
            if (gate_en && (e2 > GATE_Q16 || e2 < -GATE_Q16)) dist_err <= '0;
          end
          step  <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          p    <= mul_a * $signed({1'b0, mul_b});
          step <= step + 1'b1;
          case (step)
            4'd1: dint <= sat48(dint, p);
            4'd2: hint <= sat48(hint, p);
            4'd3: lin  <= 55'(p >>> 16);
            4'd4: lin  <= lin + 55'(p);
            4'd5: lin  <= lin + 55'(p >>> 16);
            4'd6: ang  <= 55'(p >>> 16);
            4'd7: ang  <= ang + 55'(p);
            4'd8: begin
              ang   <= ang + 55'(p >>> 16);
              state <= S_OUT;
            end
            default: ;
          endcase
        end
        S_OUT: begin
          // hold until the output register is free
          if (load_out) begin
            o_lin <= lin_c[20:0];
            o_ang <= ang_c[19:0];
            o_arr <= arr;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = ov;
  assign out_ch.linear_speed  = o_lin;
  assign out_ch.angular_speed = o_ang;
  assign out_ch.arrived       = o_arr;

  // Assertions
  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("sequencer state not one-hot");
  a_start: assert property (@(posedge clk) disable iff (rst) in_acc |=> state == S_CORD)
    else $error("accepted beat did not start the CORDIC");
  a_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && (!ov || out_ch.ready)) |=> (ov && state == S_IDLE))
    else $error("result not loaded into the output register");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (ov && !out_ch.ready) |=> (ov && $stable(o_ang) && $stable(o_lin)))
    else $error("stalled result changed");
endmodule
`default_nettype wire
